/* rtl/core/linear_queue_with_reverse_macros.svh */
// assertion macros for the queue rtl
// no dependencies; included by files that carry concurrent checks
`ifndef LINEAR_QUEUE_WITH_REVERSE_MACROS_SVH
`define LINEAR_QUEUE_WITH_REVERSE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define LQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define LQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LQR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/lqr_pkg.sv */
// shared types and codes for the linear queue with reverse
// no dependencies; used by controller, datapath and top level
`timescale 1ns / 1ps

package lqr_pkg;

    // operation select codes
    localparam logic [1:0] FN_ENQ  = 2'd0;
    localparam logic [1:0] FN_DEQ  = 2'd1;
    localparam logic [1:0] FN_DUMP = 2'd2;
    localparam logic [1:0] FN_REV  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       enq;           // store input word and advance tail
        logic       deq;           // advance head or reset the queue
        logic       rev_done;      // head to zero, tail to count minus one
        logic       slot_rd;       // read slot at head plus count
        logic       tmp_wr;        // copy slot read word into scratch
        logic       tmp_rd;        // read scratch from the far end
        logic       slot_wr_rev;   // write scratch word back to slot
        logic       cnt_clr;
        logic       cnt_inc;
        logic       out_load;      // load the output word register
        logic       out_from_slot; // output value from slot read data
        logic       out_last;
        logic [1:0] out_status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic tail_full;  // tail sits at the last slot
        logic cnt_last;   // count reached the final entry
        logic out_free;   // output register can take a word
    } t_stat;

endpackage

/* rtl/core/linear_queue_with_reverse.sv */
// enqueue: result word goes through the response state; dequeue: slot read then load state; both wait on output stalls
// dump of n entries: one word at a time through the slot ram registered read
// reverse of n entries: two copy passes through slot and scratch ram
// one operation at a time; a new command word is accepted only after the previous operation
// has loaded its last result word; full enqueue and operations on an empty queue only respond
// synchronous active-low reset empties the queue; slot contents are not cleared
`timescale 1ns / 1ps

module linear_queue_with_reverse #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] data
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] value
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast
);

    lqr_pkg::t_cmd  w_cmd;
    lqr_pkg::t_stat w_stat;
    logic signed [31:0] w_out_value;

    // operation sequencer
    lqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_func     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and output word
    lqr_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_data       (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_value  (w_out_value),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = w_out_value;

endmodule

/* rtl/core/lqr_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/lqr_ctrl.sv */
// operation sequencer for the linear queue
// depends on lqr_pkg for command, status and code definitions
`timescale 1ns / 1ps

module lqr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    output logic              o_in_ready,
    input  lqr_pkg::t_stat    i_stat,
    output lqr_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESP    = 4'd1;
    localparam logic [3:0] S_DEQ_RD  = 4'd2;
    localparam logic [3:0] S_DEQ_LD  = 4'd3;
    localparam logic [3:0] S_DUMP_RD = 4'd4;
    localparam logic [3:0] S_DUMP_LD = 4'd5;
    localparam logic [3:0] S_REV_RD  = 4'd6;
    localparam logic [3:0] S_REV_WR  = 4'd7;
    localparam logic [3:0] S_REV2_RD = 4'd8;
    localparam logic [3:0] S_REV2_WR = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.cnt_clr = 1'b1;
                if (i_in_valid) begin
                    case (i_func)
                        lqr_pkg::FN_ENQ: begin
                            if (i_stat.empty || !i_stat.tail_full) begin
                                o_cmd.enq = 1'b1;
                                n_status  = lqr_pkg::ST_OK;
                            end else begin
                                n_status  = lqr_pkg::ST_FULL;
                            end
                            n_state = S_RESP;
                        end
                        lqr_pkg::FN_DEQ: begin
                            if (i_stat.empty) begin
                                n_status = lqr_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_DEQ_RD;
                            end
                        end
                        lqr_pkg::FN_DUMP: begin
                            if (i_stat.empty) begin
                                n_status = lqr_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_DUMP_RD;
                            end
                        end
                        lqr_pkg::FN_REV: begin
                            if (i_stat.empty) begin
                                n_status = lqr_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_REV_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // single status word with zero value
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DEQ_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_DEQ_LD;
            end
            S_DEQ_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_from_slot = 1'b1;
                    o_cmd.out_status    = lqr_pkg::ST_OK;
                    o_cmd.out_last      = 1'b1;
                    o_cmd.deq           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            // walk head to tail, one word per read
            S_DUMP_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_from_slot = 1'b1;
                    o_cmd.out_status    = lqr_pkg::ST_OK;
                    o_cmd.out_last      = i_stat.cnt_last;
                    if (i_stat.cnt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_DUMP_RD;
                    end
                end
            end
            // reverse pass one: slots into scratch in queue order
            S_REV_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_REV_WR;
            end
            S_REV_WR: begin
                o_cmd.tmp_wr = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_REV2_RD;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_REV_RD;
                end
            end
            // reverse pass two: scratch back from the far end into slot 0 up
            S_REV2_RD: begin
                o_cmd.tmp_rd = 1'b1;
                n_state      = S_REV2_WR;
            end
            S_REV2_WR: begin
                o_cmd.slot_wr_rev = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.rev_done = 1'b1;
                    n_status       = lqr_pkg::ST_OK;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_REV2_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= lqr_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

/* rtl/core/lqr_dpath.sv */
// queue storage, indices, walk counter and output word register
// depends on lqr_pkg, lqr_ram and the assertion macro header
`timescale 1ns / 1ps
`include "linear_queue_with_reverse_macros.svh"

module lqr_dpath #(
    parameter int DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lqr_pkg::t_cmd       i_cmd,
    output lqr_pkg::t_stat      o_stat,
    input  logic signed [31:0]  i_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_out_status,
    output logic signed [31:0]  o_out_value,
    output logic                o_out_last
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [AW-1:0] r_cnt, n_cnt;

    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic signed [31:0] r_out_value;
    logic               r_out_last;

    logic [AW-1:0] w_n_minus1;
    logic          w_tail_full;
    logic          w_out_free;

    logic          w_slot_wr_en;
    logic [AW-1:0] w_slot_wr_addr;
    logic [31:0]   w_slot_wr_data;
    logic [AW-1:0] w_slot_rd_addr;
    logic [31:0]   w_slot_q;
    logic [AW-1:0] w_tmp_rd_addr;
    logic [31:0]   w_tmp_q;

    // derived status
    assign w_n_minus1  = r_tail - r_head;
    assign w_tail_full = (r_tail == AW'(DEPTH - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_stat.empty     = r_empty;
    assign o_stat.tail_full = w_tail_full;
    assign o_stat.cnt_last  = (r_cnt == w_n_minus1);
    assign o_stat.out_free  = w_out_free;

    // slot and scratch addressing
    assign w_slot_wr_en   = i_cmd.enq || i_cmd.slot_wr_rev;
    assign w_slot_wr_addr = i_cmd.slot_wr_rev ? r_cnt :
                            (r_empty ? '0 : r_tail + AW'(1));
    assign w_slot_wr_data = i_cmd.slot_wr_rev ? w_tmp_q : i_data;
    assign w_slot_rd_addr = r_head + r_cnt;
    assign w_tmp_rd_addr  = w_n_minus1 - r_cnt;

    lqr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_wr_en),
        .i_wr_addr (w_slot_wr_addr),
        .i_wr_data (w_slot_wr_data),
        .i_rd_en   (i_cmd.slot_rd),
        .i_rd_addr (w_slot_rd_addr),
        .o_rd_data (w_slot_q)
    );

    lqr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_scratch (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.tmp_wr),
        .i_wr_addr (r_cnt),
        .i_wr_data (w_slot_q),
        .i_rd_en   (i_cmd.tmp_rd),
        .i_rd_addr (w_tmp_rd_addr),
        .o_rd_data (w_tmp_q)
    );

    // index and counter next values
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_empty = r_empty;
        n_cnt   = r_cnt;
        if (i_cmd.enq) begin
            if (r_empty) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b0;
            end else begin
                n_tail  = r_tail + AW'(1);
            end
        end
        if (i_cmd.deq) begin
            if (r_head == r_tail) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b1;
            end else begin
                n_head  = r_head + AW'(1);
            end
        end
        if (i_cmd.rev_done) begin
            n_head = '0;
            n_tail = w_n_minus1;
        end
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + AW'(1);
        end
    end

    // index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_cnt   <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_cnt   <= n_cnt;
        end
    end

    // output word register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_value  <= i_cmd.out_from_slot ? w_slot_q : '0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_value  = r_out_value;
    assign o_out_last   = r_out_last;

    // checks
    `LQR_ASSERT_IMP(a_empty_idx, i_clk, i_rst_n, r_empty, (r_head == '0) && (r_tail == '0), "empty queue with nonzero index")
    `LQR_ASSERT_IMP(a_head_le_tail, i_clk, i_rst_n, 1'b1, r_head <= r_tail, "head above tail")
    `LQR_ASSERT_IMP(a_enq_room, i_clk, i_rst_n, i_cmd.enq, r_empty || !w_tail_full, "enqueue into full queue")
    `LQR_ASSERT_IMP(a_deq_nonempty, i_clk, i_rst_n, i_cmd.deq, !r_empty, "dequeue from empty queue")
    `LQR_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, w_out_free, "output word overwritten")
    `LQR_ASSERT_NXT(a_rev_head, i_clk, i_rst_n, i_cmd.rev_done, (r_head == '0) && !r_empty, "reverse left head off slot 0")

endmodule

/* dv/testbench.sv */
// self-checking testbench for the linear queue with reverse
// depends on lqr_pkg and linear_queue_with_reverse; drives both stream ports
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH      = 8;
    localparam int IW         = $clog2(DEPTH);
    localparam int STALL_MAX  = 2000;  // cycles without any handshake before giving up
    localparam int HOLD_LEN   = 300;   // long receiver hold-off
    localparam int DRAIN_WAIT = 60;    // covers a full reverse pass

    // one expected output word
    typedef struct {
        logic [1:0]  status;
        logic [31:0] value;
        logic        last;
    } t_queue_word;

    // shadow queue and the output words it predicts
    class queue_scoreboard;
        logic [31:0]   slots [DEPTH];
        logic [IW-1:0] head_idx;
        logic [IW-1:0] tail_idx;
        bit            empty;
        t_queue_word   pending [$];
        int            errors;

        function new();
            head_idx = '0;
            tail_idx = '0;
            empty    = 1'b1;
            errors   = 0;
        endfunction

        function void push_word(logic [1:0] st, logic [31:0] val, logic lst);
            t_queue_word w;
            w.status = st;
            w.value  = val;
            w.last   = lst;
            pending.push_back(w);
        endfunction

        // update the shadow queue for one accepted command word
        function void note_input(logic [1:0] fn, logic [31:0] d);
            logic [31:0] tmp [DEPTH];
            int n;
            n = int'(tail_idx) - int'(head_idx) + 1;
            case (fn)
                lqr_pkg::FN_ENQ: begin
                    if (empty) begin
                        head_idx = '0;
                        tail_idx = '0;
                        slots[0] = d;
                        empty    = 1'b0;
                        push_word(lqr_pkg::ST_OK, '0, 1'b1);
                    end else if (tail_idx == IW'(DEPTH - 1)) begin
                        push_word(lqr_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        tail_idx        = tail_idx + IW'(1);
                        slots[tail_idx] = d;
                        push_word(lqr_pkg::ST_OK, '0, 1'b1);
                    end
                end
                lqr_pkg::FN_DEQ: begin
                    if (empty) begin
                        push_word(lqr_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        push_word(lqr_pkg::ST_OK, slots[head_idx], 1'b1);
                        // removing the last entry resets the queue
                        if (head_idx == tail_idx) begin
                            head_idx = '0;
                            tail_idx = '0;
                            empty    = 1'b1;
                        end else begin
                            head_idx = head_idx + IW'(1);
                        end
                    end
                end
                lqr_pkg::FN_DUMP: begin
                    if (empty) begin
                        push_word(lqr_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++)
                            push_word(lqr_pkg::ST_OK, slots[int'(head_idx) + i], i == n - 1);
                    end
                end
                default: begin
                    if (empty) begin
                        push_word(lqr_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++)
                            tmp[i] = slots[int'(head_idx) + i];
                        for (int i = 0; i < n; i++)
                            slots[i] = tmp[n - 1 - i];
                        head_idx = '0;
                        tail_idx = IW'(n - 1);
                        push_word(lqr_pkg::ST_OK, '0, 1'b1);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one accepted output word against the oldest prediction
        task check_result(logic [1:0] st, logic [31:0] val, logic lst);
            t_queue_word w;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d value=%h last=%b",
                                          st, val, lst));
            end else begin
                w = pending.pop_front();
                if (st !== w.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, w.status));
                if (val !== w.value)
                    report_mismatch($sformatf("value %h, want %h", val, w.value));
                if (lst !== w.last)
                    report_mismatch($sformatf("last %b, want %b", lst, w.last));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [31:0] s_data;
    logic [1:0]  s_func;
    logic        m_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    queue_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;
    int hold_left;
    int quiet_cycles;

    linear_queue_with_reverse #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),    // [31:0] data
        .i_s_axis_tuser (s_func),    // [1:0] func
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),  // [31:0] value
        .o_m_axis_tuser (o_m_axis_tuser),  // [1:0] status
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // receiver: random back-pressure plus a long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // output monitor and no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready)
                sb.check_result(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
            if ((o_m_axis_tvalid && m_ready) || (s_valid && o_s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one command word, called and returning at a falling edge
    task automatic send_word(input logic [1:0] fn, input logic [31:0] d);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_func  = fn;
        s_data  = d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(fn, d);
        @(negedge i_clk);
    endtask

    // hold the sender until every predicted word has come out
    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int r;
        bit hold_done;
        bit drain_done;
        sb           = new();
        s_valid      = 1'b0;
        s_data       = '0;
        s_func       = lqr_pkg::FN_ENQ;
        snd_idle_pct = 28;
        rcv_idle_pct = 58;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty cases on dequeue, dump and reverse
        send_word(lqr_pkg::FN_DEQ, 32'h0);
        send_word(lqr_pkg::FN_DUMP, 32'hffff_ffff);
        send_word(lqr_pkg::FN_REV, 32'h1234_5678);
        // single entry then dequeue back to the reset state
        send_word(lqr_pkg::FN_ENQ, 32'h8000_0000);
        send_word(lqr_pkg::FN_DEQ, 32'h0);
        // fill to the last slot, starting with extreme values
        send_word(lqr_pkg::FN_ENQ, 32'h7fff_ffff);
        send_word(lqr_pkg::FN_ENQ, 32'h0);
        send_word(lqr_pkg::FN_ENQ, 32'hffff_ffff);
        send_word(lqr_pkg::FN_ENQ, 32'h8000_0000);
        send_word(lqr_pkg::FN_ENQ, 32'h0000_0001);
        send_word(lqr_pkg::FN_ENQ, 32'haaaa_5555);
        send_word(lqr_pkg::FN_ENQ, 32'h5555_aaaa);
        send_word(lqr_pkg::FN_ENQ, 32'hdead_beef);
        // full, full dump and full reverse
        send_word(lqr_pkg::FN_ENQ, 32'hffff_ffff);
        send_word(lqr_pkg::FN_DUMP, 32'h0);
        send_word(lqr_pkg::FN_REV, 32'h0);
        send_word(lqr_pkg::FN_DUMP, 32'h0);
        // head moves forward but tail still at the last slot reports full
        send_word(lqr_pkg::FN_DEQ, 32'h0);
        send_word(lqr_pkg::FN_DEQ, 32'h0);
        send_word(lqr_pkg::FN_ENQ, 32'h0bad_f00d);
        // reverse compacts to slot zero, which frees room at the tail
        send_word(lqr_pkg::FN_REV, 32'h0);
        send_word(lqr_pkg::FN_ENQ, 32'hcafe_0001);
        send_word(lqr_pkg::FN_DUMP, 32'h0);

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            snd_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 58 : 0;
            rcv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 28 : 0;
            for (int k = 0; k < 49; k++) begin
                // bursts skip loop counts, so trigger once the point is passed
                if (ph == 0 && k >= 20 && !hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (ph == 2 && k >= 30 && !drain_done) begin
                    wait_drained();
                    drain_done = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 6) begin
                    // burst that runs the queue into full
                    for (int j = 0; j <= DEPTH; j++)
                        send_word(lqr_pkg::FN_ENQ, pick_word());
                    k += DEPTH;
                end else if (r < 48) begin
                    send_word(lqr_pkg::FN_ENQ, pick_word());
                end else if (r < 70) begin
                    send_word(lqr_pkg::FN_DEQ, $urandom);
                end else if (r < 85) begin
                    send_word(lqr_pkg::FN_DUMP, $urandom);
                end else begin
                    send_word(lqr_pkg::FN_REV, $urandom);
                end
            end
        end

        // drain and let the block settle
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending.size()));
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lqr_pkg.sv
rtl/core/lqr_ram.sv
rtl/core/lqr_ctrl.sv
rtl/core/lqr_dpath.sv
rtl/core/linear_queue_with_reverse.sv
dv/testbench.sv
